// ===== hdl/ntdd_pkg.sv =====
package ntdd_pkg;

    // Angles inside the pipeline are kept in 2^-16 degree.
    localparam int ACC_W        = 25;
    localparam int INNER_FRAC   = 16;
    localparam int CORDIC_STEPS = 21;
    localparam int PRESCALE     = 20;

    localparam logic [ACC_W-1:0] DEG_90  = 25'd5898240;
    localparam logic [ACC_W-1:0] DEG_180 = 25'd11796480;
    localparam logic [ACC_W-1:0] DEG_360 = 25'd23592960;

    // Rounded atan(2^-i) in 2^-16 degree.
    function automatic logic [ACC_W-1:0] arc(input int i);
        logic [ACC_W-1:0] a;
        unique case (i)
            0:  a = 25'd2949120;
            1:  a = 25'd1740967;
            2:  a = 25'd919879;
            3:  a = 25'd466945;
            4:  a = 25'd234379;
            5:  a = 25'd117304;
            6:  a = 25'd58666;
            7:  a = 25'd29335;
            8:  a = 25'd14668;
            9:  a = 25'd7334;
            10: a = 25'd3667;
            11: a = 25'd1833;
            12: a = 25'd917;
            13: a = 25'd458;
            14: a = 25'd229;
            15: a = 25'd115;
            16: a = 25'd57;
            17: a = 25'd29;
            18: a = 25'd14;
            19: a = 25'd7;
            20: a = 25'd4;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/ntdd_front.sv =====
// Sign handling, squares, norm test and the radicand for the horizontal part.
module ntdd_front #(
    parameter int CFB = 14,
    parameter int UB  = 16,
    parameter int RB  = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_x,
    input  logic signed [15:0]   i_y,
    input  logic signed [15:0]   i_z,
    input  logic [15:0]          i_thr,
    output logic                 o_valid,
    output logic                 o_ok,
    output logic                 o_sx,
    output logic                 o_sy,
    output logic [15:0]          o_ax,
    output logic [15:0]          o_ay,
    output logic [UB-1:0]        o_zc,
    output logic [2*RB-1:0]      o_rad
);

    localparam logic [UB-1:0]   ONE  = UB'(1) << CFB;
    localparam logic [2*UB-1:0] ONE2 = (2*UB)'(1) << (2*CFB);

    logic signed [16:0] xe, ye, ze, xn, yn;
    logic [16:0]        axf, ayf, azf;
    logic [UB-1:0]      azu;

    logic              r1_v, r1_sx, r1_sy;
    logic [15:0]       r1_ax, r1_ay, r1_az;
    logic [UB-1:0]     r1_zc;

    logic              r2_v, r2_sx, r2_sy;
    logic [15:0]       r2_ax, r2_ay;
    logic [UB-1:0]     r2_zc;
    logic [31:0]       r2_xx, r2_yy, r2_zz;
    logic [2*UB-1:0]   r2_zc2;

    logic [33:0]       n_sum;

    assign xe  = {i_x[15], i_x};
    assign ye  = {i_y[15], i_y};
    assign ze  = {i_z[15], i_z};
    assign xn  = i_z[15] ? -xe : xe;
    assign yn  = i_z[15] ? -ye : ye;
    assign axf = xn[16] ? 17'(-xn) : 17'(xn);
    assign ayf = yn[16] ? 17'(-yn) : 17'(yn);
    assign azf = ze[16] ? 17'(-ze) : 17'(ze);
    assign azu = UB'(azf[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            o_valid <= r2_v;
        end
    end

    assign n_sum = {2'b00, r2_xx} + {2'b00, r2_yy} + {2'b00, r2_zz};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_sx <= xn[16];
            r1_sy <= yn[16];
            r1_ax <= axf[15:0];
            r1_ay <= ayf[15:0];
            r1_az <= azf[15:0];
            r1_zc <= (azu > ONE) ? ONE : azu;

            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_zc  <= r1_zc;
            r2_xx  <= r1_ax * r1_ax;
            r2_yy  <= r1_ay * r1_ay;
            r2_zz  <= r1_az * r1_az;
            r2_zc2 <= r1_zc * r1_zc;

            o_ok  <= n_sum > {18'd0, i_thr};
            o_sx  <= r2_sx;
            o_sy  <= r2_sy;
            o_ax  <= r2_ax;
            o_ay  <= r2_ay;
            o_zc  <= r2_zc;
            o_rad <= (2*RB)'(ONE2 - r2_zc2);
        end
    end

endmodule

// ===== hdl/ntdd_sqrt.sv =====
// Floor square root, one root bit per pipeline stage, with a side channel.
module ntdd_sqrt #(
    parameter int RB  = 15,
    parameter int SBW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  logic [2*RB-1:0]    i_rad,
    input  logic [SBW-1:0]     i_side,
    output logic               o_valid,
    output logic [RB-1:0]      o_root,
    output logic [SBW-1:0]     o_side
);

    logic [2*RB-1:0] r_n   [RB];
    logic [2*RB-1:0] r_res [RB];
    logic [SBW-1:0]  r_sd  [RB];
    logic            r_v   [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        localparam logic [2*RB-1:0] BIT = (2*RB)'(1) << (2*(RB-1-k));
        logic [2*RB-1:0] p_n, p_res, t;
        logic [SBW-1:0]  p_sd;
        logic            p_v;
        if (k == 0) begin : g_first
            assign p_n   = i_rad;
            assign p_res = '0;
            assign p_sd  = i_side;
            assign p_v   = i_valid;
        end else begin : g_next
            assign p_n   = r_n[k-1];
            assign p_res = r_res[k-1];
            assign p_sd  = r_sd[k-1];
            assign p_v   = r_v[k-1];
        end
        assign t = p_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sd[k] <= p_sd;
                if (p_n >= t) begin
                    r_n[k]   <= p_n - t;
                    r_res[k] <= (p_res >> 1) + BIT;
                end else begin
                    r_n[k]   <= p_n;
                    r_res[k] <= p_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[RB-1];
    assign o_root  = r_res[RB-1][RB-1:0];
    assign o_side  = r_sd[RB-1];

endmodule

// ===== hdl/ntdd_cordic.sv =====
// First-quadrant atan2(v, u) by CORDIC vectoring, one rotation per stage.
module ntdd_cordic #(
    parameter int UB  = 16,
    parameter int SBW = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_ce,
    input  logic                             i_valid,
    input  logic [UB-1:0]                    i_u,
    input  logic [UB-1:0]                    i_v,
    input  logic [SBW-1:0]                   i_side,
    output logic                             o_valid,
    output logic signed [ntdd_pkg::ACC_W-1:0] o_acc,
    output logic [SBW-1:0]                   o_side
);

    localparam int CW = UB + ntdd_pkg::PRESCALE + 3;
    localparam int NS = ntdd_pkg::CORDIC_STEPS;
    localparam int AW = ntdd_pkg::ACC_W;
    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ZERO = 2'd1;
    localparam logic [1:0] SP_RIGHT = 2'd2;

    logic signed [CW-1:0] r_x   [NS];
    logic signed [CW-1:0] r_y   [NS];
    logic signed [AW-1:0] r_acc [NS];
    logic [1:0]           r_sp  [NS];
    logic [SBW-1:0]       r_sd  [NS];
    logic                 r_v   [NS];

    logic [1:0] n_sp;

    always_comb begin
        priority if (i_v == '0) n_sp = SP_ZERO;
        else if (i_u == '0)     n_sp = SP_RIGHT;
        else                    n_sp = SP_NONE;
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic signed [AW-1:0] ARC = $signed(ntdd_pkg::arc(k));
        logic signed [CW-1:0] p_x, p_y;
        logic signed [AW-1:0] p_acc;
        logic [1:0]           p_sp;
        logic [SBW-1:0]       p_sd;
        logic                 p_v;
        if (k == 0) begin : g_first
            assign p_x   = $signed({3'b000, i_u, {ntdd_pkg::PRESCALE{1'b0}}});
            assign p_y   = $signed({3'b000, i_v, {ntdd_pkg::PRESCALE{1'b0}}});
            assign p_acc = '0;
            assign p_sp  = n_sp;
            assign p_sd  = i_side;
            assign p_v   = i_valid;
        end else begin : g_next
            assign p_x   = r_x[k-1];
            assign p_y   = r_y[k-1];
            assign p_acc = r_acc[k-1];
            assign p_sp  = r_sp[k-1];
            assign p_sd  = r_sd[k-1];
            assign p_v   = r_v[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sp[k] <= p_sp;
                r_sd[k] <= p_sd;
                if (!p_y[CW-1]) begin
                    r_x[k]   <= p_x + (p_y >>> k);
                    r_y[k]   <= p_y - (p_x >>> k);
                    r_acc[k] <= p_acc + ARC;
                end else begin
                    r_x[k]   <= p_x - (p_y >>> k);
                    r_y[k]   <= p_y + (p_x >>> k);
                    r_acc[k] <= p_acc - ARC;
                end
            end
        end
    end

    always_comb begin
        unique case (r_sp[NS-1])
            SP_ZERO:  o_acc = '0;
            SP_RIGHT: o_acc = $signed(ntdd_pkg::DEG_90);
            default:  o_acc = r_acc[NS-1];
        endcase
    end

    assign o_valid = r_v[NS-1];
    assign o_side  = r_sd[NS-1];

endmodule

// ===== hdl/normal_to_dip_and_dip_direction.sv =====
// Converts a stream of surface normals into dip and dip direction.
// The slave channel carries one normal per transaction: tdata holds the
// signed east, north and up components. The master channel returns one
// result per normal: tdata holds the dip and the dip direction in
// 2^-ANGLE_FRAC_BITS degree, and tuser is high when the squared norm lies
// above the zero-norm threshold; otherwise both angles read as zero.
// The threshold is written through i_cfg_wr_en / i_cfg_wr_data and resets
// to 32; the user must write it only while the block is idle, which the
// block itself does not enforce. The pipeline has three front stages, one
// square-root stage per root bit, one CORDIC stage per rotation and two
// stages for quadrant mapping and rounding. Throughput is one transaction
// per cycle while the receiver does not stall. The whole pipeline advances
// together; when the receiver stalls with a result waiting, o_s_tready
// drops and every stage holds its contents, so nothing is lost or repeated.
// Reset clears all valid bits and restores the threshold.
module normal_to_dip_and_dip_direction #(
    parameter int COMPONENT_FRAC_BITS = 14,
    parameter int ANGLE_FRAC_BITS     = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // normal_x [15:0], normal_y [31:16], normal_z [47:32]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // dip_angle [12:0], dip_azimuth [27:13], zero fill [31:28]
    output logic [31:0] o_m_tdata,
    // angles_valid [0]
    output logic        o_m_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int CFB  = COMPONENT_FRAC_BITS;
    localparam int UB   = ((CFB > 15) ? CFB : 15) + 1;
    localparam int RB   = CFB + 1;
    localparam int AW   = ntdd_pkg::ACC_W;
    localparam int SH   = ntdd_pkg::INNER_FRAC - ANGLE_FRAC_BITS;
    localparam logic [AW:0] HALF = (SH == 0) ? '0 : ((AW+1)'(1) << ((SH == 0) ? 0 : SH - 1));
    localparam logic [AW:0] FULL = (AW+1)'(360) << ANGLE_FRAC_BITS;
    localparam int SBW  = 3 + 32 + UB;

    logic            ce;
    logic [15:0]     r_thr;

    logic            f_v, f_ok, f_sx, f_sy;
    logic [15:0]     f_ax, f_ay;
    logic [UB-1:0]   f_zc;
    logic [2*RB-1:0] f_rad;

    logic            s_v;
    logic [RB-1:0]   s_root;
    logic [SBW-1:0]  s_side;
    logic            s_ok, s_sx, s_sy;
    logic [15:0]     s_ax, s_ay;
    logic [UB-1:0]   s_zc;

    logic                 cd_v, ca_v;
    logic signed [AW-1:0] cd_acc, ca_acc;
    logic                 cd_ok;
    logic [1:0]           ca_sd;

    logic [AW-1:0] n_dip, n_phi;
    logic          r1_v, r1_ok;
    logic [AW-1:0] r1_dip, r1_theta;
    logic [AW:0]   n_dip_r, n_az_r;
    logic [AW:0]   n_az;

    logic          r_m_valid, r_m_ok;
    logic [12:0]   r_m_dip;
    logic [14:0]   r_m_az;

    assign ce         = !r_m_valid || i_m_tready;
    assign o_s_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd32;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    ntdd_front #(.CFB(CFB), .UB(UB), .RB(RB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_tvalid),
        .i_x     ($signed(i_s_tdata[15:0])),
        .i_y     ($signed(i_s_tdata[31:16])),
        .i_z     ($signed(i_s_tdata[47:32])),
        .i_thr   (r_thr),
        .o_valid (f_v),
        .o_ok    (f_ok),
        .o_sx    (f_sx),
        .o_sy    (f_sy),
        .o_ax    (f_ax),
        .o_ay    (f_ay),
        .o_zc    (f_zc),
        .o_rad   (f_rad)
    );

    // The azimuth operands ride along with the root so both angles line up.
    ntdd_sqrt #(.RB(RB), .SBW(SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_v),
        .i_rad   (f_rad),
        .i_side  ({f_ok, f_sx, f_sy, f_ax, f_ay, f_zc}),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign {s_ok, s_sx, s_sy, s_ax, s_ay, s_zc} = s_side;

    // Dip: atan2(horizontal part, |z|).
    ntdd_cordic #(.UB(UB), .SBW(1)) u_cordic_dip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_v),
        .i_u     (s_zc),
        .i_v     (UB'(s_root)),
        .i_side  (s_ok),
        .o_valid (cd_v),
        .o_acc   (cd_acc),
        .o_side  (cd_ok)
    );

    // Dip direction, first quadrant: atan2(|x|, |y|).
    ntdd_cordic #(.UB(UB), .SBW(2)) u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_v),
        .i_u     (UB'(s_ay)),
        .i_v     (UB'(s_ax)),
        .i_side  ({s_sx, s_sy}),
        .o_valid (ca_v),
        .o_acc   (ca_acc),
        .o_side  (ca_sd)
    );

    // Clamp both angles to the first quadrant.
    always_comb begin
        priority if (cd_acc < 0)                         n_dip = '0;
        else if (cd_acc > $signed(ntdd_pkg::DEG_90))     n_dip = ntdd_pkg::DEG_90;
        else                                             n_dip = cd_acc;
        priority if (ca_acc < 0)                         n_phi = '0;
        else if (ca_acc > $signed(ntdd_pkg::DEG_90))     n_phi = ntdd_pkg::DEG_90;
        else                                             n_phi = ca_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (ce) begin
            r1_v      <= cd_v && ca_v;
            r_m_valid <= r1_v;
        end
    end

    // First output stage: quadrant mapping from the signs of x and y.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_ok  <= cd_ok;
            r1_dip <= n_dip;
            unique case (ca_sd)
                2'b00:   r1_theta <= n_phi;
                2'b10:   r1_theta <= ntdd_pkg::DEG_360 - n_phi;
                2'b01:   r1_theta <= ntdd_pkg::DEG_180 - n_phi;
                default: r1_theta <= ntdd_pkg::DEG_180 + n_phi;
            endcase
        end
    end

    // Last stage: round half up, fold a full circle back to zero.
    assign n_dip_r = ({1'b0, r1_dip} + HALF) >> SH;
    assign n_az_r  = ({1'b0, r1_theta} + HALF) >> SH;
    assign n_az    = (n_az_r == FULL) ? '0 : n_az_r;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m_ok  <= r1_ok;
            r_m_dip <= r1_ok ? n_dip_r[12:0] : 13'd0;
            r_m_az  <= r1_ok ? n_az[14:0] : 15'd0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0000, r_m_az, r_m_dip};
    assign o_m_tuser  = r_m_ok;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("invalid normal with nonzero angles");
    a_dip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (ANGLE_FRAC_BITS <= 6)) |->
            ({19'd0, o_m_tdata[12:0]} <= (32'd90 << ANGLE_FRAC_BITS)))
        else $error("dip above ninety degrees");
    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (ANGLE_FRAC_BITS <= 6)) |->
            ({17'd0, o_m_tdata[27:13]} < (32'd360 << ANGLE_FRAC_BITS)))
        else $error("dip direction not below full circle");
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cd_v == ca_v)
        else $error("angle pipelines out of step");
`endif

endmodule

// ===== test/normal_to_dip_and_dip_direction_tb.sv =====
module normal_to_dip_and_dip_direction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth of the block; the drain wait adds margin.
    localparam int PIPE_DEPTH  = 41;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } normal_t;

    typedef struct {
        logic [12:0] dip;
        logic [14:0] azimuth;
        logic        valid;
    } attitude_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // normal_x [15:0], normal_y [31:16], normal_z [47:32]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // dip_angle [12:0], dip_azimuth [27:13], zero fill [31:28]
    logic        o_m_tuser;   // angles_valid [0]
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    normal_to_dip_and_dip_direction u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Predictor state: only the threshold register.
    logic [15:0] norm_floor;

    normal_t   pending_normals[$];
    attitude_t expected_attitudes[$];
    int        fail_count;
    longint    cycle_count;

    // Floor right shift on a signed value, as an arithmetic shift does.
    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint isqrt(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) begin
                r = r + (longint'(1) << b);
            end
        end
        return r;
    endfunction

    // First-quadrant atan2(v, u) in 2^-16 degree by CORDIC vectoring.
    function automatic longint first_quadrant_angle(longint u, longint v);
        longint px, py, dx, dy, acc;
        if (v == 0) return 0;
        if (u == 0) return longint'(ntdd_pkg::DEG_90);
        px = u <<< ntdd_pkg::PRESCALE;
        py = v <<< ntdd_pkg::PRESCALE;
        acc = 0;
        for (int i = 0; i < ntdd_pkg::CORDIC_STEPS; i++) begin
            dx = asr(py, i);
            dy = asr(px, i);
            if (py >= 0) begin
                px = px + dx;
                py = py - dy;
                acc = acc + longint'(ntdd_pkg::arc(i));
            end else begin
                px = px - dx;
                py = py + dy;
                acc = acc - longint'(ntdd_pkg::arc(i));
            end
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ntdd_pkg::DEG_90)) acc = longint'(ntdd_pkg::DEG_90);
        return acc;
    endfunction

    // Round 2^-16 degree to 2^-6 degree, half up.
    function automatic longint to_sixty_fourths(longint a);
        return (a + 512) >>> 10;
    endfunction

    function automatic attitude_t orient(normal_t n);
        attitude_t r;
        longint x, y, z, nsq, phi, theta, az, zc, h;
        x = n.nx;
        y = n.ny;
        z = n.nz;
        nsq = x * x + y * y + z * z;
        r.dip = '0;
        r.azimuth = '0;
        r.valid = 1'b0;
        if (nsq <= longint'(norm_floor)) return r;
        if (z < 0) begin
            x = -x;
            y = -y;
        end
        phi = first_quadrant_angle(y < 0 ? -y : y, x < 0 ? -x : x);
        if (y >= 0) theta = (x >= 0) ? phi : longint'(ntdd_pkg::DEG_360) - phi;
        else theta = (x >= 0) ? longint'(ntdd_pkg::DEG_180) - phi
                              : longint'(ntdd_pkg::DEG_180) + phi;
        az = to_sixty_fourths(theta);
        if (az == 360 * 64) az = 0;
        zc = z < 0 ? -z : z;
        if (zc > 16384) zc = 16384;
        h = isqrt(longint'(16384) * 16384 - zc * zc);
        r.dip = 13'(to_sixty_fourths(first_quadrant_angle(zc, h)));
        r.azimuth = 15'(az);
        r.valid = 1'b1;
        return r;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
        return $urandom_range(0, 3);
    endfunction

    // Slave-side acceptance is captured at the rising edge so the driver
    // sees a settled value on the following falling edge.
    logic o_s_tready_q;
    always @(posedge i_clk) begin
        o_s_tready_q <= o_s_tready;
    end

    // Driver: presents the oldest pending normal, with random gaps between
    // transactions outside burst mode. Inputs change on the falling edge.
    int  send_gap;
    bit  burst_mode;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready_q) begin
                expected_attitudes.push_back(orient(pending_normals.pop_front()));
                send_gap = burst_mode ? 0 : gap_length();
            end
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_normals.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_normals[0];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stalls, toggled on the falling edge.
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n || burst_mode) begin
            i_m_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            stall_left = gap_length();
            i_m_tready <= (stall_left == 0);
        end
    end

    // Monitor: checks each result against the oldest expectation.
    always @(posedge i_clk) begin
        attitude_t want;
        cycle_count++;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_attitudes.size() == 0) begin
                $error("result with nothing expected: tdata=%h tuser=%b", o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                want = expected_attitudes.pop_front();
                if (o_m_tdata[12:0] !== want.dip) begin
                    $error("dip_angle: expected %0d, got %0d", want.dip, o_m_tdata[12:0]);
                    fail_count++;
                end
                if (o_m_tdata[27:13] !== want.azimuth) begin
                    $error("dip_azimuth: expected %0d, got %0d", want.azimuth,
                           o_m_tdata[27:13]);
                    fail_count++;
                end
                if (o_m_tuser !== want.valid) begin
                    $error("angles_valid: expected %0b, got %0b", want.valid, o_m_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_normal(int x, int y, int z);
        normal_t n;
        n.nx = 16'(x);
        n.ny = 16'(y);
        n.nz = 16'(z);
        pending_normals.push_back(n);
    endtask

    // Random component, mostly in range with the odd out-of-range value so
    // that every input bit toggles.
    function automatic int rand_component();
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0) return 0;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    task automatic drain();
        while (pending_normals.size() > 0 || expected_attitudes.size() > 0 || i_s_tvalid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // The threshold is only written with the pipeline empty.
    task automatic write_threshold(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        norm_floor = value;
    endtask

    task automatic random_burst(int count);
        int x, y, z;
        for (int k = 0; k < count; k++) begin
            x = rand_component();
            y = rand_component();
            z = rand_component();
            // Sometimes shrink the vector near the threshold.
            if ($urandom_range(0, 7) == 0) begin
                x = $urandom_range(0, 16) - 8;
                y = $urandom_range(0, 16) - 8;
                z = $urandom_range(0, 16) - 8;
            end
            queue_normal(x, y, z);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        burst_mode    = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        norm_floor    = 16'd32;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: axes, four octants, downward normals, vertical normals,
        // zero z, out-of-range and the most negative code, threshold edges.
        queue_normal(0, 0, 16384);
        queue_normal(0, 0, -16384);
        queue_normal(16384, 0, 0);
        queue_normal(-16384, 0, 0);
        queue_normal(0, 16384, 0);
        queue_normal(0, -16384, 0);
        queue_normal(9459, 9459, 9459);
        queue_normal(-9459, 9459, -9459);
        queue_normal(9459, -9459, 9459);
        queue_normal(-9459, -9459, -9459);
        queue_normal(-1, 16384, 0);
        queue_normal(1, 16384, 1);
        queue_normal(-32768, -32768, -32768);
        queue_normal(32767, 32767, 32767);
        queue_normal(0, 0, 20000);
        queue_normal(0, 0, 0);
        queue_normal(4, 4, 0);
        queue_normal(4, 4, 1);
        queue_normal(0, 5, -5);
        queue_normal(3, 0, 0);
        drain();

        // Random phases over a range of thresholds, extremes included.
        write_threshold(16'd0);
        queue_normal(0, 0, 0);
        queue_normal(1, 0, 0);
        random_burst(90);
        drain();
        write_threshold(16'hFFFF);
        queue_normal(255, 0, 0);
        queue_normal(256, 0, 0);
        random_burst(90);
        drain();
        write_threshold(16'(($urandom_range(0, 65535))));
        random_burst(90);
        drain();
        // One phase with no idling on either side.
        burst_mode = 1'b1;
        write_threshold(16'd32);
        random_burst(90);
        drain();
        burst_mode = 1'b0;
        write_threshold(16'd100);
        random_burst(90);
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
